@@ sv/mtep_pkg.sv @@
package mtep_pkg;

  // Track storage sizing.
  localparam int TRACK_COUNT = 16;
  localparam int TRACK_W     = 4;
  localparam int TRK_AW      = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int TRK_EXT_W   = (TRK_AW > TRACK_W) ? TRK_AW : TRACK_W;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int DELTA_W = 28;
  localparam int TEMPO_W = 24;
  localparam int KIND_W  = 3;

  // Byte constants of the file format.
  localparam logic [BYTE_W-1:0] STATUS_BIT     = 8'h80;
  localparam logic [BYTE_W-1:0] DATA_MASK      = 8'h7F;
  localparam logic [BYTE_W-1:0] META_STATUS    = 8'hFF;
  localparam logic [BYTE_W-1:0] TEMPO_TYPE     = 8'h51;
  localparam logic [BYTE_W-1:0] ONE_DATA_LO    = 8'hC0;
  localparam logic [BYTE_W-1:0] ONE_DATA_HI    = 8'hDF;
  localparam logic [BYTE_W-1:0] TWO_DATA_LO    = 8'h80;
  localparam logic [BYTE_W-1:0] TWO_DATA_HI    = 8'hBF;
  localparam logic [BYTE_W-1:0] BEND_LO        = 8'hE0;
  localparam logic [BYTE_W-1:0] BEND_HI        = 8'hEF;
  localparam logic [BYTE_W-1:0] NOTE_ON        = 8'h90;
  localparam logic [BYTE_W-1:0] NOTE_OFF_MASK  = 8'h8F;
  localparam logic [BYTE_W-1:0] HIGH_NIB_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] TEMPO_BYTES    = 8'd3;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ONE_DATA = 3'd0,
    KIND_TWO_DATA = 3'd1,
    KIND_META     = 3'd2,
    KIND_UNKNOWN  = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_t;

  // Per-track parse phase.
  typedef enum logic [6:0] {
    PH_DELTA  = 7'b0000001,
    PH_STATUS = 7'b0000010,
    PH_DATA1  = 7'b0000100,
    PH_DATA2  = 7'b0001000,
    PH_MTYPE  = 7'b0010000,
    PH_MLEN   = 7'b0100000,
    PH_MBODY  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [DELTA_W-1:0]  delta;
    logic [BYTE_W-1:0]   running_status;
    logic [BYTE_W-1:0]   current_status;
    logic [BYTE_W-1:0]   held_first_data;
    logic [BYTE_W-1:0]   meta_length_seen;
    logic [BYTE_W-1:0]   meta_bytes_left;
    logic [TEMPO_W-1:0]  tempo;
    logic                running_flag;
  } trk_state_t;

  localparam trk_state_t TRK_STATE_CLEAR = '{
    phase:            PH_DELTA,
    delta:            '0,
    running_status:   '0,
    current_status:   '0,
    held_first_data:  '0,
    meta_length_seen: '0,
    meta_bytes_left:  '0,
    tempo:            '0,
    running_flag:     1'b0
  };

  typedef struct packed {
    logic [TRACK_W-1:0] track_index;
    logic [BYTE_W-1:0]  chunk_byte;
    logic               first_of_track;
    logic               last_of_track;
  } in_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] event_track;
    logic [KIND_W-1:0]  event_kind;
    logic [DELTA_W-1:0] delta_ticks;
    logic [BYTE_W-1:0]  status_value;
    logic [BYTE_W-1:0]  first_data;
    logic [BYTE_W-1:0]  second_data;
    logic [TEMPO_W-1:0] tempo_value;
    logic               used_running_status;
    logic               end_of_track;
  } out_item_t;

  typedef struct packed {
    logic zero_velocity_as_note_off;
  } cfg_item_t;

  // Channel messages with one data byte: program change, channel pressure.
  function automatic logic is_one_data(input logic [BYTE_W-1:0] s);
    is_one_data = (s >= ONE_DATA_LO) && (s <= ONE_DATA_HI);
  endfunction

  // Channel messages with two data bytes.
  function automatic logic is_two_data(input logic [BYTE_W-1:0] s);
    is_two_data = ((s >= TWO_DATA_LO) && (s <= TWO_DATA_HI)) ||
                  ((s >= BEND_LO) && (s <= BEND_HI));
  endfunction

endpackage

@@ sv/mtep_in_if.sv @@
interface mtep_in_if;
  logic               valid;
  logic               ready;
  mtep_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/mtep_out_if.sv @@
interface mtep_out_if;
  logic                valid;
  logic                ready;
  mtep_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/mtep_cfg_if.sv @@
interface mtep_cfg_if;
  logic                valid;
  logic                ready;
  mtep_pkg::cfg_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/midi_track_event_parser_top.sv @@
// A byte waits in the input register while the compute stage parses it; its result, if
// any, is held in the output register for out_ch. Throughput: one byte per cycle when
// out_ch does not stall; the per-track state is read, updated and written back in the
// single compute stage, so bytes of the same track may follow back to back.
// Reset (rst_n low, synchronous) returns every track to the delta phase with all
// per-track state cleared, empties both pipeline registers and enables the rewrite.
module midi_track_event_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  mtep_in_if.sink       in_ch,
  mtep_out_if.source    out_ch,
  mtep_cfg_if.sink      cfg_ch
);
  import mtep_pkg::*;

  // Pipeline registers.
  logic       in_vld_r, in_vld_nxt;
  in_item_t   in_item_r;
  logic       out_vld_r, out_vld_nxt;
  out_item_t  out_item_r;
  logic       zv_r;

  // Per-track state.
  trk_state_t trk_r [TRACK_COUNT];

  logic                 advance;
  logic                 fire;
  logic                 in_range;
  logic [TRK_EXT_W-1:0] trk_ext;
  logic [TRK_AW-1:0]    trk_idx;
  trk_state_t           cur;
  trk_state_t           nxt;
  logic                 res_vld;
  out_item_t            res;
  logic [BYTE_W-1:0]    b;
  logic [BYTE_W-1:0]    meta_pos;
  logic [BYTE_W-1:0]    left_dec;
  logic [BYTE_W-1:0]    st2;
  logic [BYTE_W-1:0]    d2;

  // Handshakes: the compute stage moves when the result slot is free or draining.
  assign advance      = !out_vld_r || out_ch.ready;
  assign fire         = in_vld_r && advance;
  assign in_ch.ready  = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld_r;
  assign out_ch.payload = out_item_r;

  // Track lookup.
  assign trk_ext  = TRK_EXT_W'(in_item_r.track_index);
  assign trk_idx  = trk_ext[TRK_AW-1:0];
  assign in_range = (int'(in_item_r.track_index) < TRACK_COUNT);
  assign b        = in_item_r.chunk_byte;
  assign cur      = in_item_r.first_of_track ? TRK_STATE_CLEAR : trk_r[trk_idx];
  assign meta_pos = cur.meta_length_seen - cur.meta_bytes_left;
  assign left_dec = cur.meta_bytes_left - 8'd1;

  // Note-on with zero velocity rewrite.
  always_comb begin
    st2 = cur.current_status;
    d2  = b;
    if (zv_r && ((cur.current_status & HIGH_NIB_MASK) == NOTE_ON) && (b == '0)) begin
      st2 = cur.current_status & NOTE_OFF_MASK;
      d2  = DATA_MASK;
    end
  end

  // Parse one byte against its track's state.
  always_comb begin
    nxt     = cur;
    res_vld = 1'b0;
    res     = '0;
    res.event_track = in_item_r.track_index;
    res.delta_ticks = cur.delta;

    unique case (cur.phase)
      PH_DELTA: begin
        nxt.delta = {cur.delta[DELTA_W-8:0], b[6:0]};
        if ((b & STATUS_BIT) == '0) begin
          nxt.phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if ((b & STATUS_BIT) == '0) begin
          if ((cur.running_status & STATUS_BIT) == '0) begin
            // Data byte with no running status held.
            res_vld        = 1'b1;
            res.event_kind = KIND_UNKNOWN;
            res.first_data = b;
          end else begin
            nxt.current_status  = cur.running_status;
            nxt.held_first_data = b;
            nxt.running_flag    = 1'b1;
            if (is_one_data(cur.running_status)) begin
              res_vld                 = 1'b1;
              res.event_kind          = KIND_ONE_DATA;
              res.status_value        = cur.running_status;
              res.first_data          = b;
              res.used_running_status = 1'b1;
            end else begin
              nxt.phase = PH_DATA2;
            end
          end
        end else if (b == META_STATUS) begin
          nxt.current_status = META_STATUS;
          nxt.phase          = PH_MTYPE;
        end else if (is_one_data(b) || is_two_data(b)) begin
          nxt.current_status = b;
          nxt.running_status = b;
          nxt.running_flag   = 1'b0;
          nxt.phase          = PH_DATA1;
        end else begin
          // System exclusive and other status bytes are not decoded.
          res_vld          = 1'b1;
          res.event_kind   = KIND_UNKNOWN;
          res.status_value = b;
        end
      end
      PH_DATA1: begin
        nxt.held_first_data = b;
        if (is_one_data(cur.current_status)) begin
          res_vld                 = 1'b1;
          res.event_kind          = KIND_ONE_DATA;
          res.status_value        = cur.current_status;
          res.first_data          = b;
          res.used_running_status = cur.running_flag;
        end else begin
          nxt.phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res_vld                 = 1'b1;
        res.event_kind          = KIND_TWO_DATA;
        res.status_value        = st2;
        res.first_data          = cur.held_first_data;
        res.second_data         = d2;
        res.used_running_status = cur.running_flag;
      end
      PH_MTYPE: begin
        nxt.held_first_data = b;
        nxt.phase           = PH_MLEN;
      end
      PH_MLEN: begin
        nxt.meta_length_seen = b;
        nxt.meta_bytes_left  = b;
        nxt.tempo            = '0;
        if (b == '0) begin
          res_vld          = 1'b1;
          res.event_kind   = KIND_META;
          res.status_value = META_STATUS;
          res.first_data   = cur.held_first_data;
        end else begin
          nxt.phase = PH_MBODY;
        end
      end
      PH_MBODY: begin
        // Tempo takes the first three body bytes, most significant first.
        if ((cur.held_first_data == TEMPO_TYPE) && (meta_pos < TEMPO_BYTES)) begin
          nxt.tempo = {cur.tempo[TEMPO_W-9:0], b};
        end
        nxt.meta_bytes_left = left_dec;
        if (left_dec == '0) begin
          res_vld          = 1'b1;
          res.event_kind   = KIND_META;
          res.status_value = META_STATUS;
          res.first_data   = cur.held_first_data;
          res.second_data  = cur.meta_length_seen;
          res.tempo_value  = (cur.held_first_data == TEMPO_TYPE) ? nxt.tempo : '0;
        end
      end
      default: begin
        nxt.phase = PH_DELTA;
      end
    endcase

    // A track ending mid-event reports what was taken so far.
    if (in_item_r.last_of_track && !res_vld) begin
      res_vld                 = 1'b1;
      res                     = '0;
      res.event_track         = in_item_r.track_index;
      res.event_kind          = KIND_TRUNC;
      res.delta_ticks         = nxt.delta;
      res.status_value        = nxt.current_status;
      res.used_running_status = nxt.running_flag;
    end
    res.end_of_track = in_item_r.last_of_track;

    // A finished event or a track end starts a new delta.
    if (res_vld) begin
      nxt.phase          = PH_DELTA;
      nxt.delta          = '0;
      nxt.current_status = '0;
      nxt.running_flag   = 1'b0;
    end
  end

  // Valid flags of the two pipeline registers.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ch.valid && in_ch.ready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = res_vld && in_range;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      zv_r      <= 1'b1;
      for (int i = 0; i < TRACK_COUNT; i++) begin
        trk_r[i] <= TRK_STATE_CLEAR;
      end
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        zv_r <= cfg_ch.payload.zero_velocity_as_note_off;
      end
      if (fire && in_range) begin
        trk_r[trk_idx] <= nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.payload;
    end
    if (fire && res_vld) begin
      out_item_r <= res;
    end
  end

  // Meta results always carry the meta status byte.
  a_meta_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_item_r.event_kind == KIND_META)) |->
      (out_item_r.status_value == META_STATUS))
    else $error("meta result without meta status");

  // A truncated result only happens on a track's last byte.
  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_item_r.event_kind == KIND_TRUNC)) |-> out_item_r.end_of_track)
    else $error("truncated result away from track end");

  // Running status only applies to channel messages or a cut-off one.
  a_running_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.used_running_status) |->
      ((out_item_r.event_kind == KIND_ONE_DATA) ||
       (out_item_r.event_kind == KIND_TWO_DATA) ||
       (out_item_r.event_kind == KIND_TRUNC)))
    else $error("running status flagged on a non-channel result");

  // A byte that leaves the compute stage without a result frees the output slot.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !(res_vld && in_range)) |=> !out_vld_r)
    else $error("result slot filled by a byte without a result");

endmodule

@@ tb/tb_midi_track_event_parser_top.sv @@
module tb_midi_track_event_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtep_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int PIPE_SETTLE  = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 130;
  localparam int PHASE_COUNT  = 4;
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 240;
  localparam int REPORT_MAX   = 10;

  // Per-track parse context kept by the scoreboard.
  typedef struct packed {
    phase_t              phase;
    logic [DELTA_W-1:0]  delta;
    logic [BYTE_W-1:0]   run_status;
    logic [BYTE_W-1:0]   cur_status;
    logic [BYTE_W-1:0]   first_held;
    logic [BYTE_W-1:0]   meta_len;
    logic [BYTE_W-1:0]   meta_left;
    logic [TEMPO_W-1:0]  tempo;
    logic                from_running;
  } track_ctx_t;

  // One row of the directed stimulus; known rows carry a hand-written result.
  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mtep_in_if  in_ch ();
  mtep_out_if out_ch ();
  mtep_cfg_if cfg_ch ();

  midi_track_event_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  track_ctx_t   ctx [TRACK_COUNT];
  bit           note_off_rewrite;
  out_item_t    expected_events [$];
  script_row_t  script [$];
  in_item_t     pending [TRACK_COUNT][$];
  logic [BYTE_W-1:0] gen_status [TRACK_COUNT];
  int           fault_count;
  int           in_count;
  int           stall_cycles = 0;
  bit           calm_in;
  bit           calm_out;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Number of data bytes a channel status carries; zero for anything else.
  function automatic int chan_data_count(logic [BYTE_W-1:0] s);
    if (s >= ONE_DATA_LO && s <= ONE_DATA_HI) return 1;
    if ((s >= TWO_DATA_LO && s <= TWO_DATA_HI) || (s >= BEND_LO && s <= BEND_HI)) return 2;
    return 0;
  endfunction

  // Builds a finished event from the track context and rewinds it to the delta phase.
  function automatic out_item_t close_event(int t, kind_t k, logic [BYTE_W-1:0] st,
                                            logic [BYTE_W-1:0] d1, logic [BYTE_W-1:0] d2,
                                            logic [TEMPO_W-1:0] tp, logic run);
    out_item_t ev;
    ev.event_track         = TRACK_W'(t);
    ev.event_kind          = k;
    ev.delta_ticks         = ctx[t].delta;
    ev.status_value        = st;
    ev.first_data          = d1;
    ev.second_data         = d2;
    ev.tempo_value         = tp;
    ev.used_running_status = run;
    ev.end_of_track        = 1'b0;
    ctx[t].phase        = PH_DELTA;
    ctx[t].delta        = '0;
    ctx[t].cur_status   = '0;
    ctx[t].from_running = 1'b0;
    return ev;
  endfunction

  // Advances one track by one byte; returns 1 when the byte finishes an event.
  function automatic bit parse_track_byte(input in_item_t it, output out_item_t ev);
    int t;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] st;
    logic [BYTE_W-1:0] d2;
    logic [BYTE_W-1:0] pos;
    bit got;
    t   = it.track_index;
    b   = it.chunk_byte;
    got = 1'b0;
    ev  = '0;
    if (t >= TRACK_COUNT) return 1'b0;
    if (it.first_of_track) begin
      ctx[t] = '0;
      ctx[t].phase = PH_DELTA;
    end

    case (ctx[t].phase)
      PH_DELTA: begin
        ctx[t].delta = {ctx[t].delta[DELTA_W-8:0], b[6:0]};
        if (!b[7]) ctx[t].phase = PH_STATUS;
      end
      PH_STATUS: begin
        if (!b[7]) begin
          // Data byte in status position: reuse the running status if one is held.
          if (!ctx[t].run_status[7]) begin
            ev  = close_event(t, KIND_UNKNOWN, '0, b, '0, '0, 1'b0);
            got = 1'b1;
          end else begin
            ctx[t].cur_status   = ctx[t].run_status;
            ctx[t].first_held   = b;
            ctx[t].from_running = 1'b1;
            if (chan_data_count(ctx[t].run_status) == 1) begin
              ev  = close_event(t, KIND_ONE_DATA, ctx[t].run_status, b, '0, '0, 1'b1);
              got = 1'b1;
            end else begin
              ctx[t].phase = PH_DATA2;
            end
          end
        end else if (b == META_STATUS) begin
          ctx[t].cur_status = META_STATUS;
          ctx[t].phase      = PH_MTYPE;
        end else if (chan_data_count(b) != 0) begin
          ctx[t].cur_status   = b;
          ctx[t].run_status   = b;
          ctx[t].from_running = 1'b0;
          ctx[t].phase        = PH_DATA1;
        end else begin
          ev  = close_event(t, KIND_UNKNOWN, b, '0, '0, '0, 1'b0);
          got = 1'b1;
        end
      end
      PH_DATA1: begin
        ctx[t].first_held = b;
        if (chan_data_count(ctx[t].cur_status) == 1) begin
          ev  = close_event(t, KIND_ONE_DATA, ctx[t].cur_status, b, '0, '0,
                            ctx[t].from_running);
          got = 1'b1;
        end else begin
          ctx[t].phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        st = ctx[t].cur_status;
        d2 = b;
        // With the rewrite on, a note-on with zero velocity is reported as a full-velocity note-off.
        if (note_off_rewrite && (st & HIGH_NIB_MASK) == NOTE_ON && d2 == '0) begin
          st = st & NOTE_OFF_MASK;
          d2 = DATA_MASK;
        end
        ev  = close_event(t, KIND_TWO_DATA, st, ctx[t].first_held, d2, '0,
                          ctx[t].from_running);
        got = 1'b1;
      end
      PH_MTYPE: begin
        ctx[t].first_held = b;
        ctx[t].phase      = PH_MLEN;
      end
      PH_MLEN: begin
        ctx[t].meta_len  = b;
        ctx[t].meta_left = b;
        ctx[t].tempo     = '0;
        if (b == '0) begin
          ev  = close_event(t, KIND_META, META_STATUS, ctx[t].first_held, '0, '0, 1'b0);
          got = 1'b1;
        end else begin
          ctx[t].phase = PH_MBODY;
        end
      end
      PH_MBODY: begin
        pos = ctx[t].meta_len - ctx[t].meta_left;
        if (ctx[t].first_held == TEMPO_TYPE && pos < TEMPO_BYTES)
          ctx[t].tempo = {ctx[t].tempo[TEMPO_W-9:0], b};
        ctx[t].meta_left = ctx[t].meta_left - 8'd1;
        if (ctx[t].meta_left == '0) begin
          ev  = close_event(t, KIND_META, META_STATUS, ctx[t].first_held, ctx[t].meta_len,
                            (ctx[t].first_held == TEMPO_TYPE) ? ctx[t].tempo : '0, 1'b0);
          got = 1'b1;
        end
      end
      default: ctx[t].phase = PH_DELTA;
    endcase

    // The last byte of a chunk always reports, truncating an open event.
    if (it.last_of_track) begin
      if (!got) begin
        ev  = close_event(t, KIND_TRUNC, ctx[t].cur_status, '0, '0, '0,
                          ctx[t].from_running);
        got = 1'b1;
      end
      ev.end_of_track     = 1'b1;
      ctx[t].phase        = PH_DELTA;
      ctx[t].delta        = '0;
      ctx[t].cur_status   = '0;
      ctx[t].from_running = 1'b0;
    end
    return got;
  endfunction

  function automatic string describe(out_item_t e);
    return $sformatf("trk=%0d kind=%0d dt=%h st=%h d1=%h d2=%h tempo=%h run=%0d eot=%0d",
                     e.event_track, e.event_kind, e.delta_ticks, e.status_value,
                     e.first_data, e.second_data, e.tempo_value, e.used_running_status,
                     e.end_of_track);
  endfunction

  function automatic out_item_t known_event(int trk, kind_t k, logic [DELTA_W-1:0] dt,
                                            logic [BYTE_W-1:0] st, logic [BYTE_W-1:0] d1,
                                            logic [BYTE_W-1:0] d2, logic [TEMPO_W-1:0] tp,
                                            bit eot);
    out_item_t e;
    e = '{event_track: TRACK_W'(trk), event_kind: k, delta_ticks: dt, status_value: st,
          first_data: d1, second_data: d2, tempo_value: tp, used_running_status: 1'b0,
          end_of_track: eot};
    return e;
  endfunction

  function automatic void add_row(int trk, logic [BYTE_W-1:0] b, bit f, bit l);
    script_row_t r;
    r.item  = '{track_index: TRACK_W'(trk), chunk_byte: b, first_of_track: f,
                last_of_track: l};
    r.known = 1'b0;
    r.want  = '0;
    script.push_back(r);
  endfunction

  function automatic void add_known_row(int trk, logic [BYTE_W-1:0] b, bit f, bit l,
                                        out_item_t want);
    add_row(trk, b, f, l);
    script[script.size() - 1].known = 1'b1;
    script[script.size() - 1].want  = want;
  endfunction

  // Mostly plain 7-bit data, now and then a byte with the top bit set.
  function automatic logic [BYTE_W-1:0] rand_data();
    if ($urandom_range(0, 15) == 0) return BYTE_W'($urandom_range(128, 255));
    return BYTE_W'($urandom_range(0, 127));
  endfunction

  function automatic void push_channel_data(ref logic [BYTE_W-1:0] seq [$],
                                            input logic [BYTE_W-1:0] s);
    seq.push_back(rand_data());
    if (chan_data_count(s) == 2) begin
      if ((s & HIGH_NIB_MASK) == NOTE_ON && $urandom_range(0, 2) == 0)
        seq.push_back('0);
      else
        seq.push_back(rand_data());
    end
  endfunction

  // Queues the bytes of one mostly well-formed event for a track.
  task automatic gen_event(int t);
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] mtype;
    int n_delta;
    int len;
    int pick;
    int cut;
    bit fresh;
    bit close_chunk;
    fresh = ($urandom_range(0, 24) == 0);
    if (fresh) gen_status[t] = '0;

    // Delta time, usually one byte, sometimes long enough to wrap.
    pick    = $urandom_range(0, 19);
    n_delta = (pick < 12) ? 1 : (pick < 16) ? 2 : (pick < 18) ? 3 : (pick < 19) ? 4 : 5;
    for (int i = 0; i < n_delta - 1; i++) seq.push_back(BYTE_W'($urandom_range(128, 255)));
    seq.push_back(BYTE_W'($urandom_range(0, 127)));

    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      s = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
      seq.push_back(s);
      gen_status[t] = s;
      push_channel_data(seq, s);
    end else if (pick < 62) begin
      if (gen_status[t][7]) push_channel_data(seq, gen_status[t]);
      else seq.push_back(BYTE_W'($urandom_range(0, 127)));
    end else if (pick < 78) begin
      seq.push_back(META_STATUS);
      mtype = $urandom_range(0, 1) ? TEMPO_TYPE : BYTE_W'($urandom_range(0, 255));
      seq.push_back(mtype);
      if ($urandom_range(0, 59) == 0) len = 255;
      else if (mtype == TEMPO_TYPE && $urandom_range(0, 1)) len = 3;
      else len = $urandom_range(0, 5);
      seq.push_back(BYTE_W'(len));
      for (int i = 0; i < len; i++) seq.push_back(BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 86) begin
      seq.push_back(BYTE_W'($urandom_range(8'hF0, 8'hFE)));
    end else begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) seq.push_back(BYTE_W'($urandom_range(0, 255)));
    end

    // Now and then end the chunk, sometimes in the middle of an event.
    cut         = seq.size();
    close_chunk = 1'b0;
    if (seq.size() > 1 && $urandom_range(0, 29) == 0) begin
      cut         = $urandom_range(1, seq.size() - 1);
      close_chunk = 1'b1;
    end else if ($urandom_range(0, 24) == 0) begin
      close_chunk = 1'b1;
    end
    for (int i = 0; i < cut; i++)
      pending[t].push_back('{track_index: TRACK_W'(t), chunk_byte: seq[i],
                             first_of_track: fresh && i == 0,
                             last_of_track: close_chunk && i == cut - 1});
  endtask

  // Offers one byte after a random gap and records what its transfer should produce.
  task automatic offer_byte(input in_item_t it, input bit known, input out_item_t want);
    out_item_t ev;
    bit got;
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_count++;
    got = parse_track_byte(it, ev);
    if (known) expected_events.push_back(want);
    else if (got) expected_events.push_back(ev);
  endtask

  // Register writes happen only once the block has drained.
  task automatic write_rewrite_reg(bit value);
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{zero_velocity_as_note_off: value};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid     <= 1'b0;
    note_off_rewrite = value;
  endtask

  function automatic void check_result(out_item_t act);
    out_item_t e;
    bit bad;
    if (expected_events.size() == 0) begin
      fault_count++;
      if (fault_count <= REPORT_MAX) $display("unexpected result: %s", describe(act));
      return;
    end
    e   = expected_events.pop_front();
    bad = (act.event_track !== e.event_track) || (act.event_kind !== e.event_kind) ||
          (act.delta_ticks !== e.delta_ticks) || (act.status_value !== e.status_value) ||
          (act.first_data !== e.first_data) || (act.second_data !== e.second_data) ||
          (act.tempo_value !== e.tempo_value) ||
          (act.used_running_status !== e.used_running_status) ||
          (act.end_of_track !== e.end_of_track);
    if (bad) begin
      fault_count++;
      if (fault_count <= REPORT_MAX) begin
        $display("mismatch expected: %s", describe(e));
        $display("mismatch actual:   %s", describe(act));
      end
    end
  endfunction

  // Watchdog: a run with no transfer on any channel for too long has hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off to fill the block.
  initial begin : result_side
    int gap;
    bit held_off;
    held_off       = 1'b0;
    out_ch.ready  <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && in_count >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      gap = calm_out ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      check_result(out_ch.payload);
    end
  end

  // Input side: reset, directed table, then random phases under each register value.
  initial begin : byte_side
    int t;
    fault_count      = 0;
    in_count         = 0;
    calm_in          = 1'b0;
    calm_out         = 1'b0;
    note_off_rewrite = 1'b1;
    for (int i = 0; i < TRACK_COUNT; i++) begin
      ctx[i]        = '0;
      ctx[i].phase  = PH_DELTA;
      gen_status[i] = '0;
    end
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    rst_n          <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Track 0: data byte with no running status, two-byte delta, zero-velocity note-on.
    add_row(0, 8'h00, 1'b1, 1'b0);
    add_known_row(0, 8'h45, 1'b0, 1'b0,
                  known_event(0, KIND_UNKNOWN, '0, 8'h00, 8'h45, '0, '0, 1'b0));
    add_row(0, 8'h81, 1'b0, 1'b0);
    add_row(0, 8'h00, 1'b0, 1'b0);
    add_row(0, 8'h90, 1'b0, 1'b0);
    add_row(0, 8'h3C, 1'b0, 1'b0);
    add_known_row(0, 8'h00, 1'b0, 1'b0,
                  known_event(0, KIND_TWO_DATA, 28'd128, 8'h80, 8'h3C, 8'h7F, '0, 1'b0));
    // Track 1: tempo meta event.
    add_row(1, 8'h00, 1'b1, 1'b0);
    add_row(1, 8'hFF, 1'b0, 1'b0);
    add_row(1, 8'h51, 1'b0, 1'b0);
    add_row(1, 8'h03, 1'b0, 1'b0);
    add_row(1, 8'h07, 1'b0, 1'b0);
    add_row(1, 8'hA1, 1'b0, 1'b0);
    add_known_row(1, 8'h20, 1'b0, 1'b0,
                  known_event(1, KIND_META, '0, 8'hFF, 8'h51, 8'h03, 24'h07A120, 1'b0));
    // Track 15: five-byte delta that saturates all 28 bits, then a system status byte.
    add_row(15, 8'hFF, 1'b1, 1'b0);
    add_row(15, 8'hFF, 1'b0, 1'b0);
    add_row(15, 8'hFF, 1'b0, 1'b0);
    add_row(15, 8'hFF, 1'b0, 1'b0);
    add_row(15, 8'h7F, 1'b0, 1'b0);
    add_known_row(15, 8'hF0, 1'b0, 1'b1,
                  known_event(15, KIND_UNKNOWN, 28'hFFFFFFF, 8'hF0, '0, '0, '0, 1'b1));
    // Track 3: one-data message with a high data byte, running status, truncated end.
    add_row(3, 8'h00, 1'b1, 1'b0);
    add_row(3, 8'hC5, 1'b0, 1'b0);
    add_row(3, 8'hFF, 1'b0, 1'b0);
    add_row(3, 8'h00, 1'b0, 1'b0);
    add_row(3, 8'h12, 1'b0, 1'b1);
    add_row(3, 8'h00, 1'b0, 1'b0);
    add_known_row(3, 8'hE3, 1'b0, 1'b1,
                  known_event(3, KIND_TRUNC, '0, 8'hE3, '0, '0, '0, 1'b1));

    foreach (script[i]) offer_byte(script[i].item, script[i].known, script[i].want);

    // Random phases: bytes of many tracks interleaved, rewrite off and on in turn.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_rewrite_reg(ph[0]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        t = $urandom_range(0, TRACK_COUNT - 1);
        if (pending[t].size() == 0) gen_event(t);
        offer_byte(pending[t].pop_front(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
